// ===== sv/blocked_entity_triple_filter_unit_macros.svh =====
// Assertion macros shared by the filter RTL.
// Expects signals named clk and rst_n in the including scope.
`ifndef BLOCKED_ENTITY_TRIPLE_FILTER_UNIT_MACROS_SVH
`define BLOCKED_ENTITY_TRIPLE_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BEF_ASSERT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BEF_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/bef_pkg.sv =====
// Package for the blocked entity triple filter.
// Types, constants and the hash used by the front, queue and probe engine.
`timescale 1ns / 1ps
`default_nettype none

package bef_pkg;

    localparam int TABLE_SLOTS = 4096;
    localparam int SLOT_AW     = $clog2(TABLE_SLOTS);
    localparam int OCC_W       = SLOT_AW + 1;
    localparam int KEY_W       = 32;
    localparam int STATUS_W    = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_TRIPLE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_KEPT     = 3'd3,
        ST_REJECTED = 3'd4
    } status_t;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [SLOT_AW-1:0] slot_t;

    // Classified item as it sits in the queue.
    typedef struct packed {
        logic  kind;
        key_t  key_a;     // first key to probe: insert key or head
        slot_t home_a;
        key_t  head;
        key_t  relation;
        key_t  tail;
        slot_t home_b;    // home slot of the tail
    } cmd_t;

    // Table entry: valid mark and key.
    typedef struct packed {
        logic valid;
        key_t key;
    } entry_t;

    function automatic slot_t home_slot(input key_t key);
        return key[SLOT_AW-1:0] ^ key[KEY_W-1 -: SLOT_AW];
    endfunction

endpackage

`default_nettype wire

// ===== sv/bef_item_if.sv =====
// Input channel of the filter: valid/ready plus one item.
// Depends on bef_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bef_item_if
    import bef_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       kind;
    logic [KEY_W-1:0] entity_key;
    logic [KEY_W-1:0] head_id;
    logic [KEY_W-1:0] relation_id;
    logic [KEY_W-1:0] tail_id;

    modport source (output valid, kind, entity_key, head_id, relation_id, tail_id,
                    input ready);
    modport sink   (input valid, kind, entity_key, head_id, relation_id, tail_id,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/bef_result_if.sv =====
// Result channel of the filter: valid/ready plus one result item.
// Depends on bef_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bef_result_if
    import bef_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    out_head;
    logic [KEY_W-1:0]    out_relation;
    logic [KEY_W-1:0]    out_tail;
    logic [KEY_W-1:0]    rejected_total;

    modport source (output valid, status, out_head, out_relation, out_tail, rejected_total,
                    input ready);
    modport sink   (input valid, status, out_head, out_relation, out_tail, rejected_total,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/bef_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bef_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

// ===== sv/bef_front.sv =====
// Front stage: accepts items, classifies them and hashes their keys.
// Depends on bef_pkg and bef_item_if.
`timescale 1ns / 1ps
`default_nettype none

module bef_front
    import bef_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bef_item_if.sink    item_in,
    output logic        push_valid,
    input  wire logic   push_ready,
    output cmd_t        push_cmd
);
    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic take;

    assign item_in.ready = !valid_reg || push_ready;
    assign take          = item_in.valid && item_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (push_ready)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next        = 1'b1;
            cmd_next.kind     = item_in.kind;
            cmd_next.head     = item_in.head_id;
            cmd_next.relation = item_in.relation_id;
            cmd_next.tail     = item_in.tail_id;
            cmd_next.home_b   = home_slot(item_in.tail_id);
            if (item_in.kind == KIND_INSERT)
            begin
                cmd_next.key_a  = item_in.entity_key;
                cmd_next.home_a = home_slot(item_in.entity_key);
            end
            else
            begin
                cmd_next.key_a  = item_in.head_id;
                cmd_next.home_a = home_slot(item_in.head_id);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cmd_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign push_valid = valid_reg;
    assign push_cmd   = cmd_reg;
endmodule

`default_nettype wire

// ===== sv/bef_queue.sv =====
// Short command queue between the front stage and the probe engine.
// Depends on bef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bef_queue
    import bef_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);
    cmd_t                slots_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != QUEUE_CW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

`default_nettype wire

// ===== sv/bef_engine.sv =====
// Probe engine: clears the table after reset, runs linear probes for
// inserts and triples, and holds the result register.
// Depends on bef_pkg, bef_result_if, bef_ram and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "blocked_entity_triple_filter_unit_macros.svh"

module bef_engine
    import bef_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    pop_valid,
    output logic         pop_ready,
    input  wire cmd_t    pop_cmd,
    bef_result_if.source result_out
);
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK
    } state_t;

    state_t              state_reg,     state_next;
    cmd_t                cmd_reg,       cmd_next;
    key_t                probe_key_reg, probe_key_next;
    slot_t               addr_reg,      addr_next;
    slot_t               cnt_reg,       cnt_next;
    logic                phase_reg,     phase_next;
    logic [OCC_W-1:0]    occ_reg,       occ_next;
    key_t                rej_reg,       rej_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    key_t                out_head_reg,  out_head_next;
    key_t                out_rel_reg,   out_rel_next;
    key_t                out_tail_reg,  out_tail_next;
    key_t                out_total_reg, out_total_next;

    logic    ram_we;
    slot_t   ram_waddr;
    entry_t  ram_wdata;
    logic    ram_re;
    slot_t   ram_raddr;
    entry_t  ram_rdata;

    logic    hit;
    logic    fin;
    status_t fin_status;
    logic    is_insert;

    bef_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign is_insert = cmd_reg.kind == KIND_INSERT;
    assign hit       = ram_rdata.valid && (ram_rdata.key == probe_key_reg);
    // A new item starts only when the result register will be free.
    assign pop_ready = (state_reg == S_IDLE) && (!out_valid_reg || result_out.ready);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        probe_key_next  = probe_key_reg;
        addr_next       = addr_reg;
        cnt_next        = cnt_reg;
        phase_next      = phase_reg;
        occ_next        = occ_reg;
        rej_next        = rej_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_head_next   = out_head_reg;
        out_rel_next    = out_rel_reg;
        out_tail_next   = out_tail_reg;
        out_total_next  = out_total_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = addr_reg;
        fin             = 1'b0;
        fin_status      = ST_KEPT;

        if (out_valid_reg && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (&addr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (pop_valid && pop_ready)
                begin
                    cmd_next       = pop_cmd;
                    probe_key_next = pop_cmd.key_a;
                    addr_next      = pop_cmd.home_a;
                    cnt_next       = '0;
                    phase_next     = 1'b0;
                    ram_re         = 1'b1;
                    ram_raddr      = pop_cmd.home_a;
                    state_next     = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (hit)
                begin
                    fin        = 1'b1;
                    fin_status = is_insert ? ST_PRESENT : ST_REJECTED;
                end
                else if (!ram_rdata.valid && is_insert)
                begin
                    ram_we          = 1'b1;
                    ram_wdata.valid = 1'b1;
                    ram_wdata.key   = probe_key_reg;
                    occ_next        = occ_reg + 1'b1;
                    fin             = 1'b1;
                    fin_status      = ST_INSERTED;
                end
                else if (!ram_rdata.valid || (&cnt_reg))
                begin
                    // Key absent: either an empty slot or the whole table walked.
                    if (is_insert)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_FULL;
                    end
                    else if (!phase_reg)
                    begin
                        probe_key_next = cmd_reg.tail;
                        addr_next      = cmd_reg.home_b;
                        cnt_next       = '0;
                        phase_next     = 1'b1;
                        ram_re         = 1'b1;
                        ram_raddr      = cmd_reg.home_b;
                    end
                    else
                    begin
                        fin        = 1'b1;
                        fin_status = ST_KEPT;
                    end
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    ram_re    = 1'b1;
                    ram_raddr = addr_reg + 1'b1;
                end

                if (fin)
                begin
                    if (fin_status == ST_REJECTED && rej_reg != '1)
                    begin
                        rej_next = rej_reg + 1'b1;
                    end
                    out_valid_next  = 1'b1;
                    out_status_next = fin_status;
                    out_head_next   = is_insert ? '0 : cmd_reg.head;
                    out_rel_next    = is_insert ? '0 : cmd_reg.relation;
                    out_tail_next   = is_insert ? '0 : cmd_reg.tail;
                    out_total_next  = rej_next;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cmd_reg        <= '0;
            probe_key_reg  <= '0;
            addr_reg       <= '0;
            cnt_reg        <= '0;
            phase_reg      <= 1'b0;
            occ_reg        <= '0;
            rej_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_INSERTED;
            out_head_reg   <= '0;
            out_rel_reg    <= '0;
            out_tail_reg   <= '0;
            out_total_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            probe_key_reg  <= probe_key_next;
            addr_reg       <= addr_next;
            cnt_reg        <= cnt_next;
            phase_reg      <= phase_next;
            occ_reg        <= occ_next;
            rej_reg        <= rej_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_head_reg   <= out_head_next;
            out_rel_reg    <= out_rel_next;
            out_tail_reg   <= out_tail_next;
            out_total_reg  <= out_total_next;
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.status         = out_status_reg;
    assign result_out.out_head       = out_head_reg;
    assign result_out.out_relation   = out_rel_reg;
    assign result_out.out_tail       = out_tail_reg;
    assign result_out.rejected_total = out_total_reg;

    `BEF_ASSERT(a_full_only_when_all_used, fin && fin_status == ST_FULL, occ_reg == OCC_W'(TABLE_SLOTS), "table full reported with free slots")
    `BEF_ASSERT(a_insert_into_empty, ram_we && state_reg == S_CHECK, !ram_rdata.valid, "insert overwrote a valid slot")
    `BEF_ASSERT(a_result_after_probe, $rose(out_valid_reg), $past(state_reg == S_CHECK), "result appeared without a probe")
    `BEF_ASSERT_NEXT(a_count_monotonic, 1'b1, rej_reg >= $past(rej_reg), "rejected count went down")
endmodule

`default_nettype wire

// ===== sv/blocked_entity_triple_filter_unit.sv =====
// Blocked entity triple filter: hash set of blocked ids and triple filter.
//
// Channels: item_in (sink) carries insert items (kind 0, entity_key) and
// triple items (kind 1, head/relation/tail); result_out (source) gives one
// result item per input item, in order. Both use valid/ready; an item moves
// on a rising edge where both are high.
// Flow: an item passes an input register and a two-entry queue, then the
// probe engine reads one table slot at a time through the single read port
// of the slot RAM. A triple reads the head chain and then, if the head is
// absent, the tail chain. The engine takes no new item until the current
// one has finished its probes.
// Reset: the rejected count is cleared; the engine then writes every one of
// the TABLE_SLOTS (4096) slots, one per cycle, clearing the valid marks, and
// processes no item until that pass is done. Up to three items are still
// taken into the front register and queue during that pass.
// Stall: a held result keeps its values; the engine starts no new item
// until the result register is free, and the queue backs up to item_in.
// Depends on bef_pkg, the interfaces, bef_front, bef_queue, bef_engine.
`timescale 1ns / 1ps
`default_nettype none

module blocked_entity_triple_filter_unit
    import bef_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    bef_item_if.sink     item_in,
    bef_result_if.source result_out
);
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    bef_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    bef_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    bef_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .result_out (result_out)
    );
endmodule

`default_nettype wire
